/* rtl/mspid_pkg.sv */
// ----------------------------------------------------------------------------
// mspid_pkg
// Shared types, codes and helpers for the motor speed regulator.
// ----------------------------------------------------------------------------
package mspid_pkg;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SETPOINT = 2'd1,
      OP_STOP     = 2'd2
   } op_type;

   localparam logic [1:0] DIR_COAST   = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   localparam logic [2:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_STARTUP_DUTY = 3'd3;
   localparam logic [2:0] CSR_STARTUP_LEN  = 3'd4;
   localparam logic [2:0] CSR_RUN_MIN_DUTY = 3'd5;
   localparam logic [2:0] CSR_FF_FORWARD   = 3'd6;
   localparam logic [2:0] CSR_FF_REVERSE   = 3'd7;

   // RPM in Q15.8 per count/ms: 60 * 1000 * 256
   localparam logic [63:0] SPEED_SCALE = 64'd15360000;

   localparam int unsigned MUL_STEPS = 32;
   localparam int unsigned NUM_W     = 56;
   localparam int unsigned CNT_W     = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPD_MUL,
      ST_DIV,
      ST_SPD_FIN,
      ST_CTRL,
      ST_PID_MUL,
      ST_PID_FIN,
      ST_FF_SETUP,
      ST_FF_MUL,
      ST_FF_FIN,
      ST_APPLY,
      ST_DONE
   } state_type;

   function automatic longint sat64(longint v, longint lo, longint hi);
      longint r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // round to nearest, ties away from zero, then drop 16 fraction bits
   function automatic longint shr_round16(longint v);
      longint m;
      longint r;
      m = (v < 0) ? -v : v;
      r = (m + 64'sd32768) >>> 16;
      return (v < 0) ? -r : r;
   endfunction

endpackage

/* rtl/motor_speed_pid_with_feedforward_top.sv */
// ----------------------------------------------------------------------------
// motor_speed_pid_with_feedforward_top
// Speed regulator: RPM from encoder counts, incremental PID with feedforward.
// ----------------------------------------------------------------------------
// A request is a millisecond tick, a new setpoint or a stop; each request
// gives one response showing the state after it. Setpoints, stops and ticks
// that do not end a sample period go from accept straight to the done state.
// A tick that closes a sample runs through one bit-serial shift-add
// multiplier and a restoring divider: speed product, speed division, then
// the three PID products and the feedforward product where the mode and the
// feedforward registers call for them. The multiplier and divider step one
// bit per cycle. A new request is taken while the previous response still
// waits on the output register.
module motor_speed_pid_with_feedforward_top #(
   parameter int unsigned SAMPLE_MS      = 20,
   parameter int unsigned COUNTS_PER_REV = 360,
   parameter int unsigned ZERO_EPS       = 1,
   parameter int unsigned PWM_LIMIT      = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [31:0]         req_encoder_count,
   input  logic signed [23:0]  req_target_speed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_duty,
   output logic [1:0]          rsp_direction,
   output logic                rsp_in_startup,
   output logic signed [23:0]  rsp_measured_speed,
   output logic signed [16:0]  rsp_feedforward_duty,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);
   import mspid_pkg::*;

   localparam longint      LimQ    = longint'(PWM_LIMIT) * 256;
   localparam int unsigned DW      = $clog2(PWM_LIMIT * 256 + 1) + 1;
   localparam int unsigned STW     = $clog2(SAMPLE_MS + 1);
   localparam int unsigned Divisor = COUNTS_PER_REV * SAMPLE_MS;
   localparam int unsigned RW      = $clog2(Divisor) + 1;
   localparam longint      Eps     = longint'(ZERO_EPS);

   // configuration
   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [7:0]         sdut_ff, rmin_ff;
   logic [15:0]        slen_ff;
   logic [63:0]        fwd_ff, rev_ff;

   state_type state_ff, state_in;

   logic [31:0]          last_count_ff, last_count_in;
   logic [STW-1:0]       sample_ff, sample_in;
   logic [15:0]          stimer_ff, stimer_in;
   logic                 sflag_ff, sflag_in;
   logic signed [23:0]   target_ff, target_in;
   logic signed [23:0]   speed_ff, speed_in;
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [23:0]   ep_ff, ep_in, ep2_ff, ep2_in, err_ff, err_in;
   logic signed [DW-1:0] drive_ff, drive_in;
   logic signed [DW-1:0] ffwd_ff, ffwd_in;
   logic signed [63:0]   pid_ff, pid_in;
   logic                 dneg_ff, dneg_in;
   logic                 srun_ff, srun_in;
   logic [63:0]          mcand_ff, mcand_in, acc_ff, acc_in;
   logic [31:0]          mplier_ff, mplier_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           term_ff, term_in;
   logic [NUM_W-1:0]     numer_ff, numer_in;
   logic [RW-1:0]        rem_ff, rem_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                duty_ff, duty_in;
   logic [1:0]                dir_ff, dir_in;
   logic                      rstart_ff, rstart_in;
   logic signed [23:0]        rspeed_ff, rspeed_in;
   logic signed [16:0]        rff_ff, rff_in;

   logic        accept;
   logic [63:0] step_acc;
   logic [RW:0] trial;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign step_acc  = acc_ff + (mplier_ff[0] ? mcand_ff : 64'd0);
   assign trial     = {rem_ff, numer_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         sdut_ff <= '0;
         slen_ff <= '0;
         rmin_ff <= '0;
         fwd_ff  <= '0;
         rev_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:    kp_ff   <= csr_wdata[31:0];
            CSR_INTEG_GAIN:   ki_ff   <= csr_wdata[31:0];
            CSR_DERIV_GAIN:   kd_ff   <= csr_wdata[31:0];
            CSR_STARTUP_DUTY: sdut_ff <= csr_wdata[7:0];
            CSR_STARTUP_LEN:  slen_ff <= csr_wdata[15:0];
            CSR_RUN_MIN_DUTY: rmin_ff <= csr_wdata[7:0];
            CSR_FF_FORWARD:   fwd_ff  <= csr_wdata;
            CSR_FF_REVERSE:   rev_ff  <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_count_ff <= '0;
         sample_ff     <= '0;
         stimer_ff     <= '0;
         sflag_ff      <= 1'b0;
         target_ff     <= '0;
         speed_ff      <= '0;
         prev_ff       <= '0;
         ep_ff         <= '0;
         ep2_ff        <= '0;
         drive_ff      <= '0;
         ffwd_ff       <= '0;
         srun_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_count_ff <= last_count_in;
         sample_ff     <= sample_in;
         stimer_ff     <= stimer_in;
         sflag_ff      <= sflag_in;
         target_ff     <= target_in;
         speed_ff      <= speed_in;
         prev_ff       <= prev_in;
         ep_ff         <= ep_in;
         ep2_ff        <= ep2_in;
         drive_ff      <= drive_in;
         ffwd_ff       <= ffwd_in;
         srun_ff       <= srun_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      pid_ff    <= pid_in;
      dneg_ff   <= dneg_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      term_ff   <= term_in;
      numer_ff  <= numer_in;
      rem_ff    <= rem_in;
      duty_ff   <= duty_in;
      dir_ff    <= dir_in;
      rstart_ff <= rstart_in;
      rspeed_ff <= rspeed_in;
      rff_ff    <= rff_in;
   end

   always_comb begin
      logic [31:0]  d;
      logic [32:0]  snext;
      longint       sp, tgt, e, kp, ki, kd, c0, c1, c2, v, total, act, rmin, sd, q, m;
      logic         ff_en;
      logic [63:0]  sel;
      logic         is_small_old;

      state_in      = state_ff;
      last_count_in = last_count_ff;
      sample_in     = sample_ff;
      stimer_in     = stimer_ff;
      sflag_in      = sflag_ff;
      target_in     = target_ff;
      speed_in      = speed_ff;
      prev_in       = prev_ff;
      ep_in         = ep_ff;
      ep2_in        = ep2_ff;
      drive_in      = drive_ff;
      ffwd_in       = ffwd_ff;
      srun_in       = srun_ff;
      err_in        = err_ff;
      pid_in        = pid_ff;
      dneg_in       = dneg_ff;
      mcand_in      = mcand_ff;
      acc_in        = acc_ff;
      mplier_in     = mplier_ff;
      cnt_in        = cnt_ff;
      term_in       = term_ff;
      numer_in      = numer_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      duty_in       = duty_ff;
      dir_in        = dir_ff;
      rstart_in     = rstart_ff;
      rspeed_in     = rspeed_ff;
      rff_in        = rff_ff;

      d     = req_encoder_count - last_count_ff;
      snext = 33'(sample_ff) + 33'd1;
      sp    = longint'(req_target_speed);
      tgt   = longint'(target_ff);
      kp    = longint'(kp_ff);
      ki    = longint'(ki_ff);
      kd    = longint'(kd_ff);
      c0    = kp + kd;
      c1    = ki - kp - 2 * kd;
      c2    = kd;
      e     = sat64(tgt - longint'(speed_ff), -64'sd8388608, 64'sd8388607);
      rmin  = ((longint'(rmin_ff) > longint'(PWM_LIMIT)) ? longint'(PWM_LIMIT)
                                                         : longint'(rmin_ff)) * 256;
      sd    = ((longint'(sdut_ff) > longint'(PWM_LIMIT)) ? longint'(PWM_LIMIT)
                                                         : longint'(sdut_ff)) * 256;
      ff_en = (fwd_ff[63:32] != 32'd0) && (rev_ff[63:32] != 32'd0);
      sel   = (tgt > 0) ? fwd_ff : rev_ff;
      is_small_old = (tgt <= Eps) && (tgt >= -Eps);
      v     = 0;
      total = longint'(ffwd_ff) + longint'(pid_ff);
      act   = 0;
      q     = 0;
      m     = 0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               priority case (req_operation)
                  OP_TICK: begin
                     if (stimer_ff != 16'hFFFF) stimer_in = stimer_ff + 16'd1;
                     sample_in = STW'(snext);
                     if (snext >= 33'(SAMPLE_MS)) begin
                        last_count_in = req_encoder_count;
                        sample_in     = '0;
                        dneg_in       = d[31];
                        mcand_in      = SPEED_SCALE;
                        mplier_in     = d[31] ? (32'd0 - d) : d;
                        acc_in        = '0;
                        cnt_in        = CNT_W'(MUL_STEPS - 1);
                        state_in      = ST_SPD_MUL;
                     end
                  end
                  OP_SETPOINT: begin
                     if ((sp <= Eps) && (sp >= -Eps)) begin
                        target_in = '0;
                        sflag_in  = 1'b0;
                        prev_in   = '0;
                        ep_in     = '0;
                        ep2_in    = '0;
                        ffwd_in   = '0;
                        drive_in  = '0;
                     end else begin
                        target_in = req_target_speed;
                        if (is_small_old || (tgt > Eps && sp < -Eps) ||
                            (tgt < -Eps && sp > Eps)) begin
                           prev_in   = '0;
                           ep_in     = '0;
                           ep2_in    = '0;
                           ffwd_in   = '0;
                           stimer_in = '0;
                           sflag_in  = (slen_ff != 16'd0) && (sdut_ff != 8'd0);
                        end
                     end
                  end
                  OP_STOP: begin
                     target_in     = '0;
                     sflag_in      = 1'b0;
                     prev_in       = '0;
                     ep_in         = '0;
                     ep2_in        = '0;
                     ffwd_in       = '0;
                     drive_in      = '0;
                     last_count_in = req_encoder_count;
                     sample_in     = '0;
                     speed_in      = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_SPD_MUL: begin
            acc_in    = step_acc;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               numer_in = step_acc[NUM_W-1:0] + NUM_W'(Divisor / 2);
               rem_in   = '0;
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= (RW + 1)'(Divisor)) begin
               rem_in   = RW'(trial - (RW + 1)'(Divisor));
               numer_in = {numer_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in   = trial[RW-1:0];
               numer_in = {numer_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = ST_SPD_FIN;
         end

         ST_SPD_FIN: begin
            q = longint'({8'd0, numer_ff});
            if (dneg_ff) speed_in = 24'(sat64(-q, -64'sd8388608, 64'sd8388607));
            else         speed_in = 24'(sat64(q, -64'sd8388608, 64'sd8388607));
            state_in = ST_CTRL;
         end

         ST_CTRL: begin
            if (is_small_old) begin
               prev_in  = '0;
               ep_in    = '0;
               ep2_in   = '0;
               ffwd_in  = '0;
               drive_in = '0;
               state_in = ST_DONE;
            end else if (sflag_ff && (stimer_ff < slen_ff)) begin
               prev_in  = '0;
               ep_in    = '0;
               ep2_in   = '0;
               drive_in = DW'((tgt > 0) ? sd : -sd);
               srun_in  = 1'b1;
               state_in = ST_FF_SETUP;
            end else begin
               if (sflag_ff) sflag_in = 1'b0;
               srun_in   = 1'b0;
               err_in    = 24'(e);
               mcand_in  = (e < 0) ? 64'(-c0) : 64'(c0);
               mplier_in = 32'((e < 0) ? -e : e);
               acc_in    = '0;
               term_in   = 2'd0;
               cnt_in    = CNT_W'(MUL_STEPS - 1);
               state_in  = ST_PID_MUL;
            end
         end

         ST_PID_MUL: begin
            acc_in    = step_acc;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               cnt_in  = CNT_W'(MUL_STEPS - 1);
               term_in = term_ff + 2'd1;
               if (term_ff == 2'd0) begin
                  m         = longint'(ep_ff);
                  mcand_in  = (m < 0) ? 64'(-c1) : 64'(c1);
                  mplier_in = 32'((m < 0) ? -m : m);
               end else if (term_ff == 2'd1) begin
                  m         = longint'(ep2_ff);
                  mcand_in  = (m < 0) ? 64'(-c2) : 64'(c2);
                  mplier_in = 32'((m < 0) ? -m : m);
               end else begin
                  state_in = ST_PID_FIN;
               end
            end
         end

         ST_PID_FIN: begin
            pid_in   = 64'(longint'(prev_ff) + shr_round16(longint'(acc_ff)));
            state_in = ST_FF_SETUP;
         end

         ST_FF_SETUP: begin
            if (!ff_en) begin
               ffwd_in  = '0;
               state_in = srun_ff ? ST_DONE : ST_APPLY;
            end else begin
               m         = longint'($signed(sel[63:32]));
               mcand_in  = (tgt < 0) ? 64'(-m) : 64'(m);
               mplier_in = 32'((tgt < 0) ? -tgt : tgt);
               acc_in    = '0;
               cnt_in    = CNT_W'(MUL_STEPS - 1);
               state_in  = ST_FF_MUL;
            end
         end

         ST_FF_MUL: begin
            acc_in    = step_acc;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = ST_FF_FIN;
         end

         ST_FF_FIN: begin
            v = shr_round16(longint'(acc_ff)) + longint'($signed(sel[31:0]));
            ffwd_in  = DW'(sat64(v, -LimQ, LimQ));
            state_in = srun_ff ? ST_DONE : ST_APPLY;
         end

         ST_APPLY: begin
            // running clamp: no reversal, lift small drive to the minimum
            if (tgt > Eps) begin
               if (total <= 0)        act = 0;
               else if (total < rmin) act = rmin;
               else                   act = sat64(total, 0, LimQ);
            end else if (tgt < -Eps) begin
               if (total >= 0)         act = 0;
               else if (-total < rmin) act = -rmin;
               else                    act = sat64(total, -LimQ, 0);
            end
            act      = sat64(act, -LimQ, LimQ);
            prev_in  = DW'(sat64(act - longint'(ffwd_ff), -LimQ, LimQ));
            ep2_in   = ep_ff;
            ep_in    = err_ff;
            drive_in = DW'(act);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               m = longint'(drive_ff);
               m = (m < 0) ? -m : m;
               q = sat64((m + 128) >>> 8, 0, 255);
               duty_in      = 8'(q);
               dir_in       = (q == 0) ? DIR_COAST : ((m != 0 && drive_ff > 0) ?
                                                      DIR_FORWARD : DIR_REVERSE);
               rstart_in    = sflag_ff;
               rspeed_in    = speed_ff;
               rff_in       = 17'(sat64(longint'(ffwd_ff), -64'sd65536, 64'sd65535));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty             = duty_ff;
   assign rsp_direction        = dir_ff;
   assign rsp_in_startup       = rstart_ff;
   assign rsp_measured_speed   = rspeed_ff;
   assign rsp_feedforward_duty = rff_ff;

   a_dir_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_direction == DIR_COAST) == (rsp_duty == 8'd0)))
      else $error("direction and duty disagree");

   a_drive_lim: assert property (@(posedge clock) disable iff (reset)
      (longint'(drive_ff) <= LimQ) && (longint'(drive_ff) >= -LimQ))
      else $error("applied drive beyond limit");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while busy");

   a_startup_tgt: assert property (@(posedge clock) disable iff (reset)
      sflag_ff |-> (target_ff != 24'sd0))
      else $error("startup active without setpoint");

endmodule

/* tb/motor_speed_pid_with_feedforward_top_test.sv */
// ----------------------------------------------------------------------------
// motor_speed_pid_with_feedforward_top_test
// Drives ticks, setpoints and stops into the speed regulator under several
// register settings and handshake idling modes. Each response is checked
// field by field against a cycle-free predictor of the control law.
// ----------------------------------------------------------------------------
module motor_speed_pid_with_feedforward_top_test;
   import mspid_pkg::*;

   localparam int unsigned SAMPLE_PERIOD = 20;
   localparam longint      CNT_PER_REV   = 360;
   localparam longint      NEAR_ZERO     = 1;
   localparam longint      DUTY_LIMIT    = 255;
   localparam longint      LIM_Q8        = DUTY_LIMIT * 256;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic [31:0]        count;
      logic signed [23:0] target;
   } request_type;

   typedef struct {
      logic [7:0]         duty;
      logic [1:0]         dir;
      logic               startup;
      logic signed [23:0] speed;
      logic signed [16:0] ff;
   } motor_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_TICK;
   logic [31:0] req_encoder_count = '0;
   logic signed [23:0] req_target_speed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_duty;
   logic [1:0] rsp_direction;
   logic rsp_in_startup;
   logic signed [23:0] rsp_measured_speed;
   logic signed [16:0] rsp_feedforward_duty;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   motor_speed_pid_with_feedforward_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   request_type   pending_reqs[$];
   motor_out_type expected_outs[$];
   int            mismatches = 0;
   int            responses_seen = 0;
   int            samples_run = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   // predictor registers and state
   logic [63:0] regs[8];
   logic [31:0] last_count;
   int unsigned sample_timer, startup_timer;
   bit          startup_flag;
   longint      target_reg, speed_reg, prev_command, error_prev, error_prev2;
   longint      drive_out, last_ff;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint round_shift16(longint v);
      longint m;
      m = (absval(v) + 32768) >>> 16;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint div_nearest(longint n, longint d);
      longint m;
      m = (absval(n) + d / 2) / d;
      return n < 0 ? -m : m;
   endfunction

   function automatic void clear_loop();
      prev_command = 0;
      error_prev   = 0;
      error_prev2  = 0;
      last_ff      = 0;
   endfunction

   function automatic longint feedforward_q8();
      longint gf, gr, v;
      logic [63:0] sel;
      gf  = longint'($signed(regs[CSR_FF_FORWARD][63:32]));
      gr  = longint'($signed(regs[CSR_FF_REVERSE][63:32]));
      sel = target_reg > 0 ? regs[CSR_FF_FORWARD] : regs[CSR_FF_REVERSE];
      if (gf == 0 || gr == 0 || absval(target_reg) <= NEAR_ZERO) begin
         last_ff = 0;
         return 0;
      end
      v = round_shift16(longint'($signed(sel[63:32])) * target_reg)
          + longint'($signed(sel[31:0]));
      v = clip(v, -LIM_Q8, LIM_Q8);
      last_ff = v;
      return v;
   endfunction

   function automatic void run_control();
      longint kp, ki, kd, rmin, sd, err, pid, ff, total, act;
      kp   = longint'($signed(regs[CSR_PROP_GAIN][31:0]));
      ki   = longint'($signed(regs[CSR_INTEG_GAIN][31:0]));
      kd   = longint'($signed(regs[CSR_DERIV_GAIN][31:0]));
      rmin = clip(longint'(regs[CSR_RUN_MIN_DUTY][7:0]), 0, DUTY_LIMIT) * 256;
      if (absval(target_reg) <= NEAR_ZERO) begin
         clear_loop();
         drive_out = 0;
         return;
      end
      if (startup_flag) begin
         if (startup_timer >= regs[CSR_STARTUP_LEN][15:0]) begin
            startup_flag = 1'b0;
         end else begin
            sd = clip(longint'(regs[CSR_STARTUP_DUTY][7:0]), 0, DUTY_LIMIT) * 256;
            void'(feedforward_q8());
            prev_command = 0;
            error_prev   = 0;
            error_prev2  = 0;
            drive_out    = target_reg > 0 ? sd : -sd;
            return;
         end
      end
      err = clip(target_reg - speed_reg, -8388608, 8388607);
      pid = prev_command + round_shift16((kp + kd) * err + (-kp + ki - 2 * kd) * error_prev
                                         + kd * error_prev2);
      ff = feedforward_q8();
      total = ff + pid;
      if (target_reg > NEAR_ZERO) begin
         if (total <= 0) act = 0;
         else if (total < rmin) act = rmin;
         else act = clip(total, 0, LIM_Q8);
      end else begin
         if (total >= 0) act = 0;
         else if (-total < rmin) act = -rmin;
         else act = clip(total, -LIM_Q8, 0);
      end
      prev_command = clip(act - ff, -LIM_Q8, LIM_Q8);
      error_prev2  = error_prev;
      error_prev   = err;
      drive_out    = act;
   endfunction

   function automatic void predict_request(request_type r);
      longint d, sp, old, m, duty;
      logic [31:0] diff;
      motor_out_type o;
      if (r.op == OP_TICK) begin
         if (startup_timer < 65535) startup_timer++;
         sample_timer++;
         if (sample_timer >= SAMPLE_PERIOD) begin
            diff = r.count - last_count;
            d = longint'($signed(diff));
            last_count   = r.count;
            sample_timer = 0;
            speed_reg = clip(div_nearest(d * 15360000, CNT_PER_REV * SAMPLE_PERIOD),
                             -8388608, 8388607);
            samples_run++;
            run_control();
         end
      end else if (r.op == OP_SETPOINT) begin
         sp  = longint'(r.target);
         old = target_reg;
         if (absval(sp) <= NEAR_ZERO) begin
            target_reg   = 0;
            startup_flag = 1'b0;
            clear_loop();
            drive_out = 0;
         end else begin
            target_reg = sp;
            if (absval(old) <= NEAR_ZERO || (old > NEAR_ZERO && sp < -NEAR_ZERO) ||
                (old < -NEAR_ZERO && sp > NEAR_ZERO)) begin
               clear_loop();
               startup_timer = 0;
               startup_flag  = regs[CSR_STARTUP_LEN][15:0] != 0 &&
                               regs[CSR_STARTUP_DUTY][7:0] != 0;
            end
         end
      end else if (r.op == OP_STOP) begin
         target_reg   = 0;
         startup_flag = 1'b0;
         clear_loop();
         drive_out    = 0;
         last_count   = r.count;
         sample_timer = 0;
         speed_reg    = 0;
      end
      m    = absval(drive_out);
      duty = clip((m + 128) / 256, 0, 255);
      o.duty    = duty[7:0];
      o.dir     = duty == 0 ? DIR_COAST : (drive_out > 0 ? DIR_FORWARD : DIR_REVERSE);
      o.startup = startup_flag;
      o.speed   = speed_reg[23:0];
      o.ff      = 17'(clip(last_ff, -65536, 65535));
      expected_outs.push_back(o);
   endfunction

   // request driver; prediction happens at the accepting edge
   always @(posedge clock) begin : req_driver
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_request('{req_operation, req_encoder_count, req_target_speed});
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid         <= 1'b1;
               req_operation     <= nxt.op;
               req_encoder_count <= nxt.count;
               req_target_speed  <= nxt.target;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH response %0d %s: got %0d expected %0d",
               responses_seen, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_monitor
      motor_out_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outs.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               w = expected_outs.pop_front();
               if (rsp_duty !== w.duty) report_mismatch("duty", rsp_duty, w.duty);
               if (rsp_direction !== w.dir)
                  report_mismatch("direction", rsp_direction, w.dir);
               if (rsp_in_startup !== w.startup)
                  report_mismatch("in_startup", rsp_in_startup, w.startup);
               if (rsp_measured_speed !== w.speed)
                  report_mismatch("measured_speed", rsp_measured_speed, w.speed);
               if (rsp_feedforward_duty !== w.ff)
                  report_mismatch("feedforward_duty", rsp_feedforward_duty, w.ff);
            end
            responses_seen++;
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
         CSR_STARTUP_DUTY, CSR_RUN_MIN_DUTY: val = {56'd0, val[7:0]};
         CSR_STARTUP_LEN: val = {48'd0, val[15:0]};
         CSR_FF_FORWARD, CSR_FF_REVERSE: ;
         default: val = {32'd0, val[31:0]};
      endcase
      regs[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_req(logic [1:0] op, logic [31:0] cnt, logic signed [23:0] tgt);
      pending_reqs.push_back('{op, cnt, tgt});
   endtask

   // checked away from the rising edge so the driver has settled
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_outs.size() != 0)
         @(negedge clock);
   endtask

   logic [31:0] enc_pos = 32'd0;

   task automatic push_ticks(int n, int rate);
      repeat (n) begin
         enc_pos += rate + $urandom_range(2);
         push_req(OP_TICK, enc_pos, 24'($urandom));
      end
   endtask

   // mostly well-formed runs: setpoint then a stretch of ticks at some speed
   task automatic random_items(int n);
      int target, start_size;
      start_size = pending_reqs.size();
      while (pending_reqs.size() - start_size < n) begin
         case ($urandom_range(19))
            0: push_req(OP_STOP, $urandom, 24'($urandom));
            1: push_req(OP_UNUSED, $urandom, 24'($urandom));
            2: push_req(OP_SETPOINT, $urandom, 24'($urandom_range(2) - 1));
            3: push_req(OP_SETPOINT, $urandom, 24'($urandom));
            4: begin
               enc_pos = $urandom;
               push_req(OP_TICK, enc_pos, 24'($urandom));
            end
            default: begin
               target = $urandom_range(40000) - 20000;
               push_req(OP_SETPOINT, $urandom, 24'(target));
               push_ticks($urandom_range(80, 10), $urandom_range(120) - 60);
            end
         endcase
      end
   endtask

   task automatic random_regs();
      for (int i = 0; i < 8; i++)
         write_reg(3'(i), {$urandom, $urandom} >> $urandom_range(40));
      write_reg(CSR_STARTUP_LEN, $urandom_range(60));
   endtask

   initial begin
      foreach (regs[i]) regs[i] = '0;
      last_count = '0;
      sample_timer = 0;
      startup_timer = 0;
      startup_flag = 1'b0;
      target_reg = 0;
      speed_reg = 0;
      drive_out = 0;
      clear_loop();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, special items and field extremes
      push_req(OP_UNUSED, 32'hFFFF_FFFF, 24'sh7FFFFF);
      push_req(OP_SETPOINT, 32'd0, 24'sh7FFFFF);
      push_req(OP_SETPOINT, 32'd0, -24'sh800000);
      push_req(OP_SETPOINT, 32'd0, 24'sd1);
      push_req(OP_STOP, 32'hFFFF_FFFF, 24'sd0);
      push_ticks(19, 0);
      push_req(OP_TICK, 32'h7FFF_FFFE, 24'sd0);
      wait_drained();

      write_reg(CSR_PROP_GAIN, 64'h0002_0000);
      write_reg(CSR_INTEG_GAIN, 64'h0000_8000);
      write_reg(CSR_DERIV_GAIN, 64'h0000_1000);
      write_reg(CSR_STARTUP_DUTY, 64'd100);
      write_reg(CSR_STARTUP_LEN, 64'd30);
      write_reg(CSR_RUN_MIN_DUTY, 64'd30);
      write_reg(CSR_FF_FORWARD, {32'h0000_0100, 32'd512});
      write_reg(CSR_FF_REVERSE, {32'h0000_0120, -32'sd512});
      push_req(OP_SETPOINT, 32'd0, 24'sd12800);
      push_ticks(60, 3);
      push_req(OP_SETPOINT, 32'd0, -24'sd12800);
      push_ticks(40, -3);
      push_req(OP_SETPOINT, 32'd0, 24'sd2);
      push_ticks(20, 0);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (ph == 3) begin
            write_reg(CSR_PROP_GAIN, 64'h7FFF_FFFF);
            write_reg(CSR_INTEG_GAIN, 64'h8000_0000);
            write_reg(CSR_DERIV_GAIN, 64'h7FFF_FFFF);
            write_reg(CSR_STARTUP_DUTY, 64'd255);
            write_reg(CSR_STARTUP_LEN, 64'hFFFF);
            write_reg(CSR_RUN_MIN_DUTY, 64'd255);
            write_reg(CSR_FF_FORWARD, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(CSR_FF_REVERSE, 64'h8000_0000_7FFF_FFFF);
         end else if (ph == 5) begin
            for (int i = 0; i < 8; i++) write_reg(3'(i), 64'd0);
         end else if (ph != 0) begin
            random_regs();
         end
         random_items(165);
         wait_drained();
      end

      repeat (300) @(posedge clock);
      $display("Checked %0d responses covering %0d control samples",
               responses_seen, samples_run);
      $display("under several register settings and handshake idling modes.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches found", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Timed out with %0d requests pending", expected_outs.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mspid_pkg.sv
rtl/motor_speed_pid_with_feedforward_top.sv
tb/motor_speed_pid_with_feedforward_top_test.sv
